### src/mrs_pkg.sv
`default_nettype none
package mrs_pkg;

  localparam int unsigned HOLDING_REGS_DEF = 16;
  localparam int unsigned INPUT_REGS_DEF   = 16;
  localparam int unsigned FRAME_BYTES_DEF  = 256;

  localparam logic [1:0] OP_RX_BYTE   = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_LOAD_REG  = 2'd2;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_GAP_TICKS  = 2'd1;

  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_EXC_FLAG     = 8'h80;

  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int unsigned MIN_FRAME = 5;
  localparam int unsigned HDR_BYTES = 6;

  typedef struct packed {
    logic        start;
    logic [15:0] init;
    logic [7:0]  data;
  } crc_req_t;

endpackage
`default_nettype wire

### src/modbus_rtu_register_slave_core.sv
`default_nettype none
// Channel  | Direction | Signals
// ---------+-----------+-----------------------------------------------------
// in       | input     | in_valid_i, in_ready_o, opcode_i, rx_byte_i,
//          |           | reg_index_i, reg_value_i
// out      | output    | out_valid_o, out_ready_i, tx_byte_o, last_o
// cfg      | input     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// A received byte passes through the bit-serial CRC unit, which runs eight steps per byte; a
// byte past the frame limit is not counted and gets no CRC run. A frame end adds an evaluation
// state, then each response byte waits for the CRC unit while the two CRC bytes do not; every
// response byte waits longer while the output transaction is stalled.
// Reset clears both register banks and the frame state and loads the default configuration.
// The block is not ready for input while a transaction is in work or output stalls.
module modbus_rtu_register_slave_core import mrs_pkg::*; #(
  parameter int unsigned HOLDING_REGS = HOLDING_REGS_DEF,
  parameter int unsigned INPUT_REGS   = INPUT_REGS_DEF,
  parameter int unsigned FRAME_BYTES  = FRAME_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [3:0]  reg_index_i,
  input  wire logic [15:0] reg_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned HW = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
  localparam int unsigned IW = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
  localparam int unsigned BIG = (HOLDING_REGS > INPUT_REGS) ? HOLDING_REGS : INPUT_REGS;
  localparam int unsigned RESP_MAX = 5 + 2 * BIG;
  localparam int unsigned KW = $clog2(RESP_MAX + 1);
  localparam int unsigned LW = $clog2(FRAME_BYTES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISTRT = 3'd1;
  localparam logic [2:0] S_ING   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  localparam logic [1:0] K_EXC = 2'd0;
  localparam logic [1:0] K_RD  = 2'd1;
  localparam logic [1:0] K_WR  = 2'd2;

  logic [2:0]  state_q;
  logic [15:0] hold_q [HOLDING_REGS];
  logic [15:0] inp_q [INPUT_REGS];
  logic [7:0]  hdr_q [HDR_BYTES];
  logic [LW-1:0] flen_q;
  logic [15:0] rcrc_q, txcrc_q, sil_q, gap_q;
  logic [7:0]  sa_q, byte_q, code_q, tx_q;
  logic        pend_q, rdh_q, outv_q, last_q;
  logic [1:0]  kind_q;
  logic [15:0] a_q, q_q;
  logic [KW-1:0] n_q, k_q;

  crc_req_t    creq;
  logic        cbusy;
  logic [15:0] ccrc;

  mrs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .busy_o (cbusy),
    .crc_o  (ccrc)
  );

  logic [15:0] sil_inc, hdr_a, hdr_q16;
  logic [16:0] a_plus_q;
  logic        frame_open_end, frame_ok;
  logic [KW-1:0] jidx;
  logic [15:0] ridx, rval;
  logic [7:0]  resp_byte;
  logic [4:0]  ld_idx;

  assign sil_inc  = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
  assign hdr_a    = {hdr_q[2], hdr_q[3]};
  assign hdr_q16  = {hdr_q[4], hdr_q[5]};
  assign a_plus_q = {1'b0, hdr_a} + {1'b0, hdr_q16};
  assign frame_ok = (flen_q >= LW'(MIN_FRAME)) && (rcrc_q == 16'd0) &&
                    ((hdr_q[0] == sa_q) || (hdr_q[0] == 8'd0)) && (hdr_q[0] != 8'd0);
  assign frame_open_end = (flen_q != '0) && (sil_q >= gap_q);
  assign ld_idx   = {1'b0, reg_index_i};

  assign jidx = k_q - KW'(3);
  assign ridx = a_q + 16'(jidx[KW-1:1]);
  assign rval = rdh_q ? hold_q[ridx[HW-1:0]] : inp_q[ridx[IW-1:0]];

  always_comb begin
    resp_byte = sa_q;
    unique case (kind_q)
      K_EXC: begin
        if (k_q == KW'(1)) resp_byte = q_q[7:0];
        else if (k_q == KW'(2)) resp_byte = code_q;
      end
      K_RD: begin
        if (k_q == KW'(1)) resp_byte = q_q[15:8];
        else if (k_q == KW'(2)) resp_byte = code_q;
        else if (k_q != '0) resp_byte = jidx[0] ? rval[7:0] : rval[15:8];
      end
      K_WR: begin
        if (k_q < KW'(HDR_BYTES)) resp_byte = hdr_q[k_q[2:0]];
      end
      default: resp_byte = sa_q;
    endcase
  end

  always_comb begin
    creq.start = 1'b0;
    creq.init  = rcrc_q;
    creq.data  = byte_q;
    if (state_q == S_ISTRT) begin
      creq.start = (flen_q < LW'(FRAME_BYTES));
      creq.init  = (flen_q == '0) ? CRC_INIT : rcrc_q;
    end else if (state_q == S_EMIT) begin
      creq.start = (k_q < n_q);
      creq.init  = txcrc_q;
      creq.data  = resp_byte;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = outv_q;
  assign tx_byte_o   = tx_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < HOLDING_REGS; i++) hold_q[i] <= 16'd0;
      for (int i = 0; i < INPUT_REGS; i++) inp_q[i] <= 16'd0;
      for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] <= 8'd0;
      flen_q  <= '0;
      rcrc_q  <= CRC_INIT;
      txcrc_q <= CRC_INIT;
      sil_q   <= 16'd0;
      gap_q   <= 16'd4;
      sa_q    <= 8'd1;
      byte_q  <= 8'd0;
      code_q  <= 8'd0;
      tx_q    <= 8'd0;
      pend_q  <= 1'b0;
      rdh_q   <= 1'b0;
      outv_q  <= 1'b0;
      last_q  <= 1'b0;
      kind_q  <= K_EXC;
      a_q     <= 16'd0;
      q_q     <= 16'd0;
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_SLAVE_ADDR) sa_q <= cfg_data_i[7:0];
        else if (cfg_index_i == CFG_GAP_TICKS) gap_q <= cfg_data_i;
      end
      if (outv_q && out_ready_i) outv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (opcode_i == OP_RX_BYTE) begin
              byte_q <= rx_byte_i;
              if (frame_open_end) begin
                pend_q  <= 1'b1;
                state_q <= S_EVAL;
              end else begin
                state_q <= S_ISTRT;
              end
            end else if (opcode_i == OP_TICK) begin
              sil_q <= sil_inc;
              if ((flen_q != '0) && (sil_inc >= gap_q)) begin
                pend_q  <= 1'b0;
                state_q <= S_EVAL;
              end
            end else if (opcode_i == OP_LOAD_REG) begin
              if (ld_idx < 5'(INPUT_REGS)) inp_q[ld_idx[IW-1:0]] <= reg_value_i;
            end
          end
        end
        S_ISTRT: begin
          sil_q  <= 16'd0;
          pend_q <= 1'b0;
          if (flen_q == '0) begin
            for (int i = 1; i < HDR_BYTES; i++) hdr_q[i] <= 8'd0;
            hdr_q[0] <= byte_q;
          end else if (flen_q < LW'(HDR_BYTES)) begin
            hdr_q[flen_q[2:0]] <= byte_q;
          end
          if (flen_q < LW'(FRAME_BYTES)) begin
            flen_q  <= flen_q + LW'(1);
            state_q <= S_ING;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_ING: begin
          if (!cbusy) begin
            rcrc_q  <= ccrc;
            state_q <= S_IDLE;
          end
        end
        S_EVAL: begin
          flen_q <= '0;
          a_q    <= hdr_a;
          rdh_q  <= (hdr_q[1] == FC_READ_HOLDING);
          k_q    <= '0;
          txcrc_q <= CRC_INIT;
          if ((hdr_q[1] == FC_READ_HOLDING) || (hdr_q[1] == FC_READ_INPUT)) begin
            if (a_plus_q > 17'((hdr_q[1] == FC_READ_HOLDING) ? HOLDING_REGS : INPUT_REGS))
            begin
              kind_q <= K_EXC;
              q_q    <= {hdr_q[1], hdr_q[1] | FC_EXC_FLAG};
              code_q <= EXC_ILLEGAL_ADDR;
              n_q    <= KW'(3);
            end else begin
              kind_q <= K_RD;
              q_q    <= {hdr_q[1], 8'd0};
              code_q <= {hdr_q16[6:0], 1'b0};
              n_q    <= KW'(3) + KW'({hdr_q16[6:0], 1'b0});
            end
          end else if (hdr_q[1] == FC_WRITE_SINGLE) begin
            if (hdr_a >= 16'(HOLDING_REGS)) begin
              kind_q <= K_EXC;
              q_q    <= {hdr_q[1], hdr_q[1] | FC_EXC_FLAG};
              code_q <= EXC_ILLEGAL_ADDR;
              n_q    <= KW'(3);
            end else begin
              kind_q <= K_WR;
              n_q    <= KW'(6);
              if (frame_ok || ((flen_q >= LW'(MIN_FRAME)) && (rcrc_q == 16'd0) &&
                               (hdr_q[0] == 8'd0))) begin
                hold_q[hdr_a[HW-1:0]] <= hdr_q16;
              end
            end
          end else begin
            kind_q <= K_EXC;
            q_q    <= {hdr_q[1], hdr_q[1] | FC_EXC_FLAG};
            code_q <= EXC_ILLEGAL_FUNC;
            n_q    <= KW'(3);
          end
          if (frame_ok) state_q <= S_EMIT;
          else state_q <= pend_q ? S_ISTRT : S_IDLE;
        end
        S_EMIT: begin
          outv_q <= 1'b1;
          last_q <= 1'b0;
          if (k_q < n_q) tx_q <= resp_byte;
          else if (k_q == n_q) tx_q <= txcrc_q[7:0];
          else begin
            tx_q   <= txcrc_q[15:8];
            last_q <= 1'b1;
          end
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!outv_q && !cbusy) begin
            if (k_q < n_q) txcrc_q <= ccrc;
            k_q <= k_q + KW'(1);
            if (last_q) state_q <= pend_q ? S_ISTRT : S_IDLE;
            else state_q <= S_EMIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/mrs_crc.sv
`default_nettype none
module mrs_crc import mrs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire crc_req_t    req_i,
  output logic             busy_o,
  output logic [15:0]      crc_o
);

  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      crc_d  = req_i.init ^ {8'd0, req_i.data};
    end else if (busy_q) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      crc_q  <= CRC_INIT;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mrs_pkg::*;

  localparam int unsigned NUM_HOLD = 16;
  localparam int unsigned NUM_INP = 16;
  localparam int unsigned MAX_FRAME = 256;
  localparam int unsigned STALL_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [3:0]  reg_index_i = '0;
  logic [15:0] reg_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  modbus_rtu_register_slave_core DUT (.*);

  always #6 clk_i = ~clk_i;

  logic [15:0] hold_regs [NUM_HOLD];
  logic [15:0] inp_regs [NUM_INP];
  logic [7:0]  hdr [6];
  int unsigned rx_len;
  logic [15:0] rx_crc;
  int unsigned quiet_ticks;
  logic [7:0]  own_addr;
  logic [15:0] gap_cfg;

  logic [8:0]  tx_expect_q [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned idle_cycles = 0;
  bit          failed = 1'b0;

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void queue_response(logic [7:0] r[], int unsigned n);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      c = crc_update(c, r[i]);
      tx_expect_q.push_back({1'b0, r[i]});
    end
    tx_expect_q.push_back({1'b0, c[7:0]});
    tx_expect_q.push_back({1'b1, c[15:8]});
  endfunction

  function automatic void close_frame();
    logic [7:0]  r[];
    int unsigned len, a, q, n, lim;
    logic [7:0]  fc;
    len = rx_len;
    rx_len = 0;
    if (len < MIN_FRAME || rx_crc != 16'h0000) return;
    if (hdr[0] != own_addr && hdr[0] != 8'h00) return;
    fc = hdr[1];
    a = 32'({hdr[2], hdr[3]});
    q = 32'({hdr[4], hdr[5]});
    r = new[5 + 2 * NUM_HOLD];
    r[0] = own_addr;
    r[1] = fc;
    if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
      lim = (fc == FC_READ_HOLDING) ? NUM_HOLD : NUM_INP;
      if (a + q > lim) begin
        r[1] = fc | FC_EXC_FLAG;
        r[2] = EXC_ILLEGAL_ADDR;
        n = 3;
      end else begin
        r[2] = 8'(q * 2);
        for (int i = 0; i < q; i++) begin
          logic [15:0] v;
          v = (fc == FC_READ_HOLDING) ? hold_regs[a + i] : inp_regs[a + i];
          r[3 + 2 * i] = v[15:8];
          r[4 + 2 * i] = v[7:0];
        end
        n = 3 + 2 * q;
      end
    end else if (fc == FC_WRITE_SINGLE) begin
      if (a >= NUM_HOLD) begin
        r[1] = fc | FC_EXC_FLAG;
        r[2] = EXC_ILLEGAL_ADDR;
        n = 3;
      end else begin
        hold_regs[a] = 16'(q);
        for (int i = 0; i < 6; i++) r[i] = hdr[i];
        n = 6;
      end
    end else begin
      r[1] = fc | FC_EXC_FLAG;
      r[2] = EXC_ILLEGAL_FUNC;
      n = 3;
    end
    if (hdr[0] != 8'h00) queue_response(r, n);
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [7:0] b, logic [3:0] idx,
                                       logic [15:0] val);
    if (op == OP_RX_BYTE) begin
      if (rx_len > 0 && quiet_ticks >= gap_cfg) close_frame();
      if (rx_len == 0) begin
        for (int i = 0; i < 6; i++) hdr[i] = 8'h00;
        rx_crc = CRC_INIT;
      end
      if (rx_len < MAX_FRAME) begin
        if (rx_len < 6) hdr[rx_len] = b;
        rx_crc = crc_update(rx_crc, b);
        rx_len++;
      end
      quiet_ticks = 0;
    end else if (op == OP_TICK) begin
      if (quiet_ticks < 16'hFFFF) quiet_ticks++;
      if (rx_len > 0 && quiet_ticks >= gap_cfg) close_frame();
    end else if (op == OP_LOAD_REG) begin
      if (idx < NUM_INP) inp_regs[idx] = val;
    end
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] b, logic [3:0] idx, logic [15:0] val);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    opcode_i <= op;
    rx_byte_i <= b;
    reg_index_i <= idx;
    reg_value_i <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(op, b, idx, val);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(OP_RX_BYTE, b, 4'($urandom), 16'($urandom));
  endtask

  task automatic send_ticks(int unsigned n);
    for (int i = 0; i < n; i++) send_item(OP_TICK, 8'($urandom), 4'($urandom), 16'($urandom));
  endtask

  task automatic send_frame(logic [7:0] body[], bit corrupt);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) begin
      c = crc_update(c, body[i]);
      send_byte(body[i]);
    end
    if (corrupt) c = c ^ 16'(1 << $urandom_range(15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    send_ticks(32'(gap_cfg));
  endtask

  task automatic send_request(logic [7:0] addr, logic [7:0] fc, logic [15:0] a, logic [15:0] q);
    logic [7:0] body[];
    body = new[6];
    body = '{addr, fc, a[15:8], a[7:0], q[15:8], q[7:0]};
    send_frame(body, 1'b0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tx_expect_q.size() != 0 || !in_ready_o);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SLAVE_ADDR) own_addr = data[7:0];
    else gap_cfg = data;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (tx_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction tx_byte %02h last %0b", $realtime,
                   tx_byte_o, last_o);
          failed = 1'b1;
        end else begin
          logic [8:0] exp_byte;
          exp_byte = tx_expect_q.pop_front();
          if (tx_byte_o !== exp_byte[7:0])
            begin
            $display("%0t: tx_byte expected %02h actual %02h", $realtime, exp_byte[7:0],
                     tx_byte_o);
            failed = 1'b1;
          end
          if (last_o !== exp_byte[8]) begin
            $display("%0t: last expected %0b actual %0b", $realtime, exp_byte[8], last_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL modbus_rtu_register_slave_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    send_item(OP_LOAD_REG, 8'h00, 4'd0, 16'hFFFF);
    send_item(OP_LOAD_REG, 8'hFF, 4'd15, 16'h0000);
    send_item(OP_LOAD_REG, 8'hA5, 4'd7, 16'h8001);
    send_request(8'd1, FC_WRITE_SINGLE, 16'd15, 16'hBEEF);
    send_request(8'd1, FC_READ_HOLDING, 16'd0, 16'd16);
    send_request(8'd1, FC_READ_INPUT, 16'd0, 16'd16);
    send_request(8'd1, FC_READ_INPUT, 16'd16, 16'd0);
    send_request(8'd1, FC_READ_HOLDING, 16'd15, 16'd2);
    send_request(8'd1, FC_READ_INPUT, 16'hFFFF, 16'hFFFF);
    send_request(8'd1, FC_WRITE_SINGLE, 16'd16, 16'd1);
    send_request(8'd1, 8'hFF, 16'd0, 16'd1);
    send_request(8'd0, FC_WRITE_SINGLE, 16'd3, 16'h1234);
    send_request(8'd0, 8'd7, 16'd0, 16'd0);
    send_request(8'd2, FC_READ_HOLDING, 16'd0, 16'd1);
    send_request(8'd1, FC_READ_HOLDING, 16'd3, 16'd1);
    send_frame('{8'h01, 8'h03, 8'h00}, 1'b1);
    send_frame('{8'h01, 8'h03, 8'h00}, 1'b0);
    send_frame('{8'h01}, 1'b0);
    send_byte(8'h01);
    send_ticks(32'(gap_cfg));
    send_item(2'd3, 8'h55, 4'd1, 16'h5555);
    wait_drained();
  endtask

  task automatic test_config();
    write_reg(CFG_SLAVE_ADDR, 16'd247);
    write_reg(CFG_GAP_TICKS, 16'd1);
    send_request(8'd247, FC_READ_HOLDING, 16'd0, 16'd4);
    send_request(8'd1, FC_READ_HOLDING, 16'd0, 16'd4);
    write_reg(CFG_GAP_TICKS, 16'd0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_ticks(2);
    wait_drained();
    write_reg(CFG_GAP_TICKS, 16'd6);
    send_byte(8'hF7);
    send_ticks(3);
    wait_drained();
    write_reg(CFG_GAP_TICKS, 16'd2);
    send_byte(8'hF7);
    send_ticks(1);
    wait_drained();
    write_reg(CFG_GAP_TICKS, 16'd65535);
    send_item(OP_TICK, 8'h00, 4'd0, 16'd0);
    wait_drained();
    write_reg(CFG_SLAVE_ADDR, 16'd0);
    write_reg(CFG_GAP_TICKS, 16'd3);
    send_request(8'd0, FC_WRITE_SINGLE, 16'd1, 16'hCAFE);
    wait_drained();
    write_reg(CFG_SLAVE_ADDR, 16'd1);
    write_reg(CFG_GAP_TICKS, 16'd4);
    wait_drained();
  endtask

  task automatic test_long_frame();
    logic [7:0] body[];
    body = new[260];
    foreach (body[i]) body[i] = 8'($urandom);
    body[0] = own_addr;
    send_frame(body, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_items, int unsigned send_pct, int unsigned recv_pct);
    int unsigned sent;
    logic [15:0] a, q;
    logic [7:0]  fc, addr;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_item(OP_LOAD_REG, 8'($urandom), 4'($urandom), 16'($urandom));
          sent++;
        end
        1: begin
          send_byte(8'($urandom));
          send_ticks($urandom_range(32'(gap_cfg)));
          sent += 2;
        end
        2: begin
          send_frame('{own_addr, 8'($urandom), 8'($urandom), 8'($urandom)},
                     1'($urandom_range(1)));
          sent += 6 + 32'(gap_cfg);
        end
        default: begin
          case ($urandom_range(3))
            0: fc = FC_READ_HOLDING;
            1: fc = FC_READ_INPUT;
            2: fc = FC_WRITE_SINGLE;
            default: fc = 8'($urandom);
          endcase
          addr = ($urandom_range(5) == 0) ? 8'($urandom_range(1)) * own_addr : own_addr;
          a = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(17));
          q = (fc == FC_WRITE_SINGLE || $urandom_range(7) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(17));
          send_request(addr, fc, a, q);
          sent += 8 + 32'(gap_cfg);
        end
      endcase
    end
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < NUM_HOLD; i++) hold_regs[i] = '0;
    for (int i = 0; i < NUM_INP; i++) inp_regs[i] = '0;
    for (int i = 0; i < 6; i++) hdr[i] = '0;
    rx_len = 0;
    rx_crc = CRC_INIT;
    quiet_ticks = 0;
    own_addr = 8'd1;
    gap_cfg = 16'd4;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_long_frame();
    test_random(15, 0, 0);
    write_reg(CFG_GAP_TICKS, 16'd1);
    test_random(15, 60, 0);
    write_reg(CFG_SLAVE_ADDR, 16'd247);
    write_reg(CFG_GAP_TICKS, 16'd2);
    test_random(15, 0, 60);
    write_reg(CFG_SLAVE_ADDR, 16'd1);
    write_reg(CFG_GAP_TICKS, 16'd4);
    test_random(15, 7, 7);
    repeat (50) @(posedge clk_i);
    if (!failed && tx_expect_q.size() == 0) begin
      $display("PASS modbus_rtu_register_slave_core");
    end else begin
      $display("FAIL modbus_rtu_register_slave_core");
    end
    $finish;
  end

endmodule

### files.f
src/mrs_pkg.sv
src/mrs_crc.sv
src/modbus_rtu_register_slave_core.sv
bench/testbench.sv
